FILE: rtl/tle_pkg.sv
`timescale 1ns / 1ps
// tle_pkg: shared constants, echo request type and register indexes
// for the terminal line editor; no dependencies

package tle_pkg;

  // line buffer geometry
  localparam int LINE_CAP = 40;
  localparam int LEN_W    = $clog2(LINE_CAP + 1);
  localparam int ADDR_W   = $clog2(LINE_CAP);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ERASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KILL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EOF   = 2'd3;

  // register reset values
  localparam logic [7:0] ERASE_RST = 8'd127;
  localparam logic [7:0] KILL_RST  = 8'd21;
  localparam logic [7:0] WORD_RST  = 8'd23;
  localparam logic [7:0] EOF_RST   = 8'd4;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  // echo sequence kinds
  typedef enum logic [2:0] {
    EK_PRINT,
    EK_PRINT_NL,
    EK_ERASE,
    EK_KILL,
    EK_WORD,
    EK_EOF,
    EK_BEL
  } echo_kind_t;

  // request from the editor core to the echo unit
  typedef struct packed {
    echo_kind_t       kind;
    logic [7:0]       ch;
    logic [LEN_W-1:0] cnt;
  } echo_req_t;

endpackage

FILE: rtl/tle_echo.sv
`timescale 1ns / 1ps
// tle_echo: expands one echo request into its byte sequence and drives
// the registered result channel; depends on tle_pkg

module tle_echo (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  tle_pkg::echo_req_t  req,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          echo_byte,
  output logic                last_of_run,
  output logic                session_end
);

  logic                busy;
  tle_pkg::echo_kind_t kind;
  logic [7:0]          ch;
  logic [3:0]          tens;
  logic [3:0]          units;
  logic [2:0]          idx;

  logic [2:0]  idx_next;
  logic [7:0]  cur_byte;
  logic        cur_last;
  logic        cur_end;
  logic        take;
  logic [6:0]  cnt7;
  logic [14:0] prod;
  logic [3:0]  tens_calc;
  logic [6:0]  units_calc;

  assign req_ready = !busy;
  assign take      = busy && (!out_valid || out_ready);

  // split the removed count (below 100) into decimal digits
  assign cnt7       = 7'(req.cnt);
  assign prod       = 15'(cnt7) * 15'd205;
  assign tens_calc  = prod[14:11];
  assign units_calc = cnt7 - ({3'b000, tens_calc} << 3) - ({3'b000, tens_calc} << 1);

  // byte and end flag at the current position of the sequence
  always_comb begin
    cur_byte = tle_pkg::CH_BEL;
    cur_last = 1'b1;
    cur_end  = 1'b0;
    case (kind)
      tle_pkg::EK_PRINT, tle_pkg::EK_PRINT_NL: begin
        cur_byte = (idx == 3'd0) ? tle_pkg::CH_NL : ch;
        cur_last = (idx == 3'd1);
      end
      tle_pkg::EK_ERASE: begin
        cur_byte = (idx == 3'd1) ? tle_pkg::CH_SPACE : tle_pkg::CH_BS;
        cur_last = (idx == 3'd2);
      end
      tle_pkg::EK_KILL: begin
        case (idx)
          3'd0:    cur_byte = tle_pkg::CH_CR;
          3'd1:    cur_byte = tle_pkg::CH_ESC;
          3'd2:    cur_byte = tle_pkg::CH_LBRK;
          3'd3:    cur_byte = tle_pkg::CH_TWO;
          default: cur_byte = tle_pkg::CH_K;
        endcase
        cur_last = (idx == 3'd4);
      end
      tle_pkg::EK_WORD: begin
        case (idx)
          3'd0:    cur_byte = tle_pkg::CH_ESC;
          3'd1:    cur_byte = tle_pkg::CH_LBRK;
          3'd2:    cur_byte = tle_pkg::CH_ZERO + {4'b0000, tens};
          3'd3:    cur_byte = tle_pkg::CH_ZERO + {4'b0000, units};
          3'd4:    cur_byte = tle_pkg::CH_D;
          3'd5:    cur_byte = tle_pkg::CH_ESC;
          3'd6:    cur_byte = tle_pkg::CH_LBRK;
          default: cur_byte = tle_pkg::CH_K;
        endcase
        cur_last = (idx == 3'd7);
      end
      tle_pkg::EK_EOF: begin
        cur_byte = tle_pkg::CH_NUL;
        cur_end  = 1'b1;
      end
      default: begin
        cur_byte = tle_pkg::CH_BEL;
      end
    endcase
  end

  // skip the tens digit when the count is a single digit
  assign idx_next = (kind == tle_pkg::EK_WORD && idx == 3'd1 && tens == 4'd0) ?
                    3'd3 : idx + 3'd1;

  // request load
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      kind  <= req.kind;
      ch    <= req.ch;
      tens  <= tens_calc;
      units <= units_calc[3:0];
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else begin
      if (req_valid && req_ready) begin
        busy <= 1'b1;
        idx  <= (req.kind == tle_pkg::EK_PRINT) ? 3'd1 : 3'd0;
      end else if (take) begin
        if (cur_last) begin
          busy <= 1'b0;
        end else begin
          idx <= idx_next;
        end
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      echo_byte   <= cur_byte;
      last_of_run <= cur_last;
      session_end <= cur_end;
    end
  end

endmodule

FILE: rtl/terminal_line_editor_top.sv
`timescale 1ns / 1ps
// terminal_line_editor_top: line buffer memory, editing control and config
// registers; depends on tle_pkg and tle_echo
//
//   channel | signals                                   | handshake
//   --------+-------------------------------------------+------------------
//   input   | in_byte                                   | in_valid/in_ready
//   result  | echo_byte, last_of_run, session_end       | out_valid/out_ready
//   config  | cfg_index, cfg_data                       | cfg_we, no wait
//
// An item is taken in the idle state; the hand-off state then passes its echo
// sequence to the output unit, waiting while that unit is busy. A word erase
// first scans back through the single read port, one memory read per entry.
// Echo bytes of a sequence leave one per cycle while out_ready is high; the next item is
// accepted while the previous sequence is still draining.
// Reset clears the line length and the session flag and loads the config
// registers with their reset values; the line memory is not cleared.

module terminal_line_editor_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       echo_byte,
  output logic                             last_of_run,
  output logic                             session_end,
  input  logic                             cfg_we,
  input  logic [tle_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                       cfg_data
);

  localparam int LW = tle_pkg::LEN_W;
  localparam int AW = tle_pkg::ADDR_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_HAND = 3'b100
  } state_t;

  state_t            state;
  logic [LW-1:0]     line_len;
  logic              ended;
  logic [7:0]        erase_char;
  logic [7:0]        kill_char;
  logic [7:0]        word_erase_char;
  logic [7:0]        eof_char;
  logic [AW-1:0]     scan_idx;
  tle_pkg::echo_req_t req;

  logic [7:0]        line_mem [tle_pkg::LINE_CAP];
  logic [7:0]        rd_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;

  logic              accept;
  logic              is_print;
  logic              is_erase;
  logic              is_kill;
  logic              is_word;
  logic              is_eof;
  logic              line_full;
  logic              len_zero;
  logic              scan_hit;
  logic              scan_done;
  logic [LW-1:0]     cut;
  logic [LW-1:0]     len_dec;
  logic              req_valid;
  logic              req_ready;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // command decode, printable bytes take priority
  assign is_print  = (in_byte >= tle_pkg::CH_SPACE) && (in_byte <= tle_pkg::CH_TILDE);
  assign is_erase  = !is_print && (in_byte == erase_char);
  assign is_kill   = !is_print && !is_erase && (in_byte == kill_char);
  assign is_word   = !is_print && !is_erase && !is_kill && (in_byte == word_erase_char);
  assign is_eof    = !is_print && !is_erase && !is_kill && !is_word &&
                     (in_byte == eof_char);
  assign line_full = (line_len >= LW'(tle_pkg::LINE_CAP));
  assign len_zero  = (line_len == '0);
  assign len_dec   = line_len - LW'(1);

  // back scan: stop on a space or at the start of the line
  assign scan_hit  = (rd_data == tle_pkg::CH_SPACE);
  assign scan_done = scan_hit || (scan_idx == '0);
  assign cut       = scan_hit ? LW'(scan_idx) : '0;

  // memory port control
  assign wr_en   = accept && !ended && is_print;
  assign wr_addr = line_full ? '0 : line_len[AW-1:0];

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_idx - AW'(1);
    if (state == ST_IDLE && accept && !ended && is_word && !len_zero) begin
      rd_en   = 1'b1;
      rd_addr = len_dec[AW-1:0];
    end else if (state == ST_SCAN && !scan_done) begin
      rd_en = 1'b1;
    end
  end

  // line buffer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= line_mem[rd_addr];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      erase_char      <= tle_pkg::ERASE_RST;
      kill_char       <= tle_pkg::KILL_RST;
      word_erase_char <= tle_pkg::WORD_RST;
      eof_char        <= tle_pkg::EOF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tle_pkg::REG_ERASE: erase_char      <= cfg_data;
        tle_pkg::REG_KILL:  kill_char       <= cfg_data;
        tle_pkg::REG_WORD:  word_erase_char <= cfg_data;
        tle_pkg::REG_EOF:   eof_char        <= cfg_data;
        default: ;
      endcase
    end
  end

  // editing control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      line_len <= '0;
      ended    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && !ended) begin
            if (is_print) begin
              line_len <= line_full ? LW'(1) : line_len + LW'(1);
              state    <= ST_HAND;
            end else if (is_erase) begin
              if (!len_zero) begin
                line_len <= len_dec;
                state    <= ST_HAND;
              end
            end else if (is_kill) begin
              line_len <= '0;
              state    <= ST_HAND;
            end else if (is_word) begin
              if (!len_zero) begin
                scan_idx <= len_dec[AW-1:0];
                state    <= ST_SCAN;
              end
            end else if (is_eof) begin
              if (len_zero) begin
                ended <= 1'b1;
                state <= ST_HAND;
              end
            end else begin
              state <= ST_HAND;
            end
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            line_len <= cut;
            state    <= ST_HAND;
          end else begin
            scan_idx <= scan_idx - AW'(1);
          end
        end
        ST_HAND: begin
          if (req_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // echo request built alongside the state update
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      req.ch  <= in_byte;
      req.cnt <= '0;
      if (is_print) begin
        req.kind <= line_full ? tle_pkg::EK_PRINT_NL : tle_pkg::EK_PRINT;
      end else if (is_erase) begin
        req.kind <= tle_pkg::EK_ERASE;
      end else if (is_kill) begin
        req.kind <= tle_pkg::EK_KILL;
      end else if (is_word) begin
        req.kind <= tle_pkg::EK_WORD;
      end else if (is_eof) begin
        req.kind <= tle_pkg::EK_EOF;
      end else begin
        req.kind <= tle_pkg::EK_BEL;
      end
    end else if (state == ST_SCAN && scan_done) begin
      req.cnt <= line_len - cut;
    end
  end

  assign req_valid = (state == ST_HAND);

  tle_echo u_echo (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .echo_byte   (echo_byte),
    .last_of_run (last_of_run),
    .session_end (session_end)
  );

endmodule
